[design/esc_pkg.sv]
// esc_pkg: shared constants, reciprocal factors and bus types for the epoch to calendar unit
// no dependencies; every design file but esc_if refers to it by scoped names

package esc_pkg;

   // seconds to whole days: drop the power of two part of 86400, then multiply by 1/675
   localparam int unsigned DaySecShift    = 7;
   localparam int unsigned DayRecipShift  = 35;
   localparam logic [25:0] DayRecip       =
      26'(((64'd1 << DayRecipShift) + 64'd674) / 64'd675);

   // serial day number of 1970-01-01 (day 1 is 0001-01-01)
   localparam logic [16:0] SecsPerDay     = 17'd86400;
   localparam logic [19:0] SerialEpoch    = 20'd719163;
   localparam logic [28:0] YearScale      = 29'd400;

   // (serial - 1) mod 7 equals (days + 3) mod 7
   localparam logic [16:0] WeekdayOffset  = 17'd3;
   localparam int unsigned WeekRecipShift = 20;
   localparam logic [17:0] WeekRecip      =
      18'(((64'd1 << WeekRecipShift) + 64'd6) / 64'd7);
   localparam logic [16:0] DaysPerWeek    = 17'd7;

   // year estimate: serial * 400 / 146097
   localparam int unsigned YearRecipShift = 47;
   localparam logic [29:0] YearRecip      =
      30'(((64'd1 << YearRecipShift) + 64'd146096) / 64'd146097);
   localparam logic [19:0] DaysPerYear    = 20'd365;
   localparam logic [19:0] LeapYearDays   = 20'd366;
   localparam logic [11:0] YearBase       = 12'd1900;

   // time of day
   localparam int unsigned HourRecipShift = 27;
   localparam logic [15:0] HourRecip      =
      16'(((64'd1 << HourRecipShift) + 64'd3599) / 64'd3600);
   localparam logic [16:0] SecsPerHour    = 17'd3600;
   localparam int unsigned MinRecipShift  = 18;
   localparam logic [12:0] MinRecip       =
      13'(((64'd1 << MinRecipShift) + 64'd59) / 64'd60);
   localparam logic [11:0] SecsPerMinute  = 12'd60;

   // month formula
   localparam logic [8:0]  FebEndDay      = 9'd59;
   localparam logic [8:0]  LeapMarchLimit = 9'd62;
   localparam logic [8:0]  FebSkip        = 9'd2;
   localparam logic [15:0] MonthScale     = 16'd100;
   localparam logic [15:0] MonthStep      = 16'd3057;
   localparam logic [15:0] MonthBase      = 16'd3007;
   localparam int unsigned MonthRecipShift = 28;
   localparam logic [16:0] MonthRecip     =
      17'(((64'd1 << MonthRecipShift) + 64'd3056) / 64'd3057);

   // divide by 100 for values below 2^16
   localparam int unsigned Div100Shift    = 23;
   localparam logic [16:0] Div100Recip    =
      17'(((64'd1 << Div100Shift) + 64'd99) / 64'd100);

   typedef struct packed {
      logic [19:0] serial;
      logic [28:0] scaled_serial;
      logic [16:0] secs;
      logic [16:0] week_base;
   } day_bus_type;

   typedef struct packed {
      logic [7:0] year_since_1900;
      logic [8:0] day_number;
      logic       leap;
   } year_bus_type;

   typedef struct packed {
      logic [2:0] weekday;
      logic [4:0] hour_of_day;
      logic [5:0] minute_of_hour;
      logic [5:0] second_of_minute;
   } clock_bus_type;

   typedef struct packed {
      logic [7:0]    year_since_1900;
      logic [3:0]    month_index;
      logic [4:0]    day_of_month;
      logic [8:0]    day_of_year;
      clock_bus_type clock_fields;
   } result_type;

   function automatic logic [9:0] div100(input logic [15:0] value);
      logic [32:0] prod;
      prod = 33'(value) * 33'(Div100Recip);
      return prod[Div100Shift +: 10];
   endfunction

endpackage

[design/esc_if.sv]
// esc_if: valid/ready channel interfaces for the epoch to calendar unit
// request carries the epoch seconds, response carries the calendar fields; no dependencies

interface esc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface esc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] year_since_1900;
   logic [3:0] month_index;
   logic [4:0] day_of_month;
   logic [8:0] day_of_year;
   logic [2:0] weekday;
   logic [4:0] hour_of_day;
   logic [5:0] minute_of_hour;
   logic [5:0] second_of_minute;

   modport source (output valid, output year_since_1900, output month_index,
      output day_of_month, output day_of_year, output weekday, output hour_of_day,
      output minute_of_hour, output second_of_minute, input ready);
   modport sink (input valid, input year_since_1900, input month_index,
      input day_of_month, input day_of_year, input weekday, input hour_of_day,
      input minute_of_hour, input second_of_minute, output ready);
endinterface

[design/esc_day_split.sv]
// esc_day_split: two stages splitting epoch seconds into whole days and seconds of day
// depends on esc_pkg

module esc_day_split (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [31:0]          in_seconds,
   output logic                 out_valid,
   output esc_pkg::day_bus_type out_bus
);

   logic                 stage_valid_ff;
   logic                 out_valid_ff;
   logic [31:0]          seconds_ff;
   logic [15:0]          days_ff;
   logic [15:0]          days_in;
   logic [50:0]          day_prod;
   logic [31:0]          day_start;
   logic [19:0]          serial;
   esc_pkg::day_bus_type bus_in;
   esc_pkg::day_bus_type bus_ff;

   assign day_prod = 51'(in_seconds[31:esc_pkg::DaySecShift]) * 51'(esc_pkg::DayRecip);
   assign days_in  = day_prod[esc_pkg::DayRecipShift +: 16];

   always_comb begin
      day_start            = 32'(days_ff) * 32'(esc_pkg::SecsPerDay);
      serial               = 20'(days_ff) + esc_pkg::SerialEpoch;
      bus_in.serial        = serial;
      bus_in.scaled_serial = 29'(serial) * esc_pkg::YearScale;
      bus_in.secs          = 17'(seconds_ff - day_start);
      bus_in.week_base     = 17'(days_ff) + esc_pkg::WeekdayOffset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else if (advance) begin
         stage_valid_ff <= in_valid;
         out_valid_ff   <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         seconds_ff <= in_seconds;
         days_ff    <= days_in;
         bus_ff     <= bus_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_bus   = bus_ff;

endmodule

[design/esc_year_find.sv]
// esc_year_find: four stages estimating the year and correcting it against day counts
// depends on esc_pkg; yields year, one-based day of year and the leap flag

module esc_year_find (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  esc_pkg::day_bus_type  in_bus,
   output logic                  out_valid,
   output esc_pkg::year_bus_type out_bus
);

   logic [3:0]            valid_ff;
   logic [58:0]           year_prod;
   logic [11:0]           est_in;
   logic [11:0]           est1_ff;
   logic [19:0]           serial1_ff;
   logic [11:0]           cand1 [4];
   logic [4:0]            q100_in [4];
   logic [2:0]            q400_in [4];
   logic [11:0]           est2_ff;
   logic [19:0]           serial2_ff;
   logic [4:0]            q100_ff [4];
   logic [2:0]            q400_ff [4];
   logic [11:0]           cand2 [4];
   logic [19:0]           diy_in [4];
   logic [11:0]           est3_ff;
   logic [19:0]           serial3_ff;
   logic [19:0]           diy_ff [4];
   logic [1:0]            pick;
   logic [19:0]           prev_days;
   logic [19:0]           curr_days;
   logic [11:0]           year;
   esc_pkg::year_bus_type bus_in;
   esc_pkg::year_bus_type bus_ff;

   assign year_prod = 59'(in_bus.scaled_serial) * 59'(esc_pkg::YearRecip);
   assign est_in    = year_prod[esc_pkg::YearRecipShift +: 12];

   // candidates run from the estimate minus one to the estimate plus two
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cand1[k]   = est1_ff - 12'd1 + 12'(k);
         q100_in[k] = 5'(esc_pkg::div100(16'(cand1[k])));
         q400_in[k] = 3'(esc_pkg::div100(16'(cand1[k] >> 2)));
         cand2[k]   = est2_ff - 12'd1 + 12'(k);
         diy_in[k]  = 20'(cand2[k]) * esc_pkg::DaysPerYear + 20'(cand2[k] >> 2)
                      - 20'(q100_ff[k]) + 20'(q400_ff[k]);
      end
   end

   // first year whose day count reaches the serial day
   always_comb begin
      if (diy_ff[1] >= serial3_ff) begin
         pick = 2'd0;
      end else if (diy_ff[2] >= serial3_ff) begin
         pick = 2'd1;
      end else begin
         pick = 2'd2;
      end
      case (pick)
         2'd0: begin
            prev_days = diy_ff[0];
            curr_days = diy_ff[1];
         end
         2'd1: begin
            prev_days = diy_ff[1];
            curr_days = diy_ff[2];
         end
         default: begin
            prev_days = diy_ff[2];
            curr_days = diy_ff[3];
         end
      endcase
      year                   = est3_ff + 12'(pick);
      bus_in.year_since_1900 = 8'(year - esc_pkg::YearBase);
      bus_in.day_number      = 9'(serial3_ff - prev_days);
      bus_in.leap            = (curr_days - prev_days) == esc_pkg::LeapYearDays;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         est1_ff    <= est_in;
         serial1_ff <= in_bus.serial;
         est2_ff    <= est1_ff;
         serial2_ff <= serial1_ff;
         q100_ff    <= q100_in;
         q400_ff    <= q400_in;
         est3_ff    <= est2_ff;
         serial3_ff <= serial2_ff;
         diy_ff     <= diy_in;
         bus_ff     <= bus_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_bus   = bus_ff;

endmodule

[design/esc_clock_fields.sv]
// esc_clock_fields: four payload stages for hour, minute, second and weekday
// depends on esc_pkg; runs alongside esc_year_find with the same latency

module esc_clock_fields (
   input  logic                   clock,
   input  logic                   advance,
   input  esc_pkg::day_bus_type   in_bus,
   output esc_pkg::clock_bus_type out_bus
);

   logic [32:0]            hour_prod;
   logic [34:0]            week_prod;
   logic [16:0]            secs1_ff;
   logic [16:0]            week1_ff;
   logic [4:0]             hour1_ff;
   logic [12:0]            wq1_ff;
   logic [11:0]            rem_in;
   logic [2:0]             wday_in;
   logic [11:0]            rem2_ff;
   logic [2:0]             wday2_ff;
   logic [4:0]             hour2_ff;
   logic [24:0]            min_prod;
   logic [11:0]            rem3_ff;
   logic [5:0]             min3_ff;
   logic [2:0]             wday3_ff;
   logic [4:0]             hour3_ff;
   esc_pkg::clock_bus_type bus_in;
   esc_pkg::clock_bus_type bus_ff;

   assign hour_prod = 33'(in_bus.secs) * 33'(esc_pkg::HourRecip);
   assign week_prod = 35'(in_bus.week_base) * 35'(esc_pkg::WeekRecip);
   assign rem_in    = 12'(secs1_ff - 17'(hour1_ff) * esc_pkg::SecsPerHour);
   assign wday_in   = 3'(week1_ff - 17'(wq1_ff) * esc_pkg::DaysPerWeek);
   assign min_prod  = 25'(rem2_ff) * 25'(esc_pkg::MinRecip);

   always_comb begin
      bus_in.weekday          = wday3_ff;
      bus_in.hour_of_day      = hour3_ff;
      bus_in.minute_of_hour   = min3_ff;
      bus_in.second_of_minute = 6'(rem3_ff - 12'(min3_ff) * esc_pkg::SecsPerMinute);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         secs1_ff <= in_bus.secs;
         week1_ff <= in_bus.week_base;
         hour1_ff <= hour_prod[esc_pkg::HourRecipShift +: 5];
         wq1_ff   <= week_prod[esc_pkg::WeekRecipShift +: 13];
         rem2_ff  <= rem_in;
         wday2_ff <= wday_in;
         hour2_ff <= hour1_ff;
         rem3_ff  <= rem2_ff;
         min3_ff  <= min_prod[esc_pkg::MinRecipShift +: 6];
         wday3_ff <= wday2_ff;
         hour3_ff <= hour2_ff;
         bus_ff   <= bus_in;
      end
   end

   assign out_bus = bus_ff;

endmodule

[design/esc_month_day.sv]
// esc_month_day: four stages applying the february correction and the 3057/3007 month formula
// depends on esc_pkg; its last stage is the response register

module esc_month_day (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  esc_pkg::year_bus_type  in_year,
   input  esc_pkg::clock_bus_type in_clock,
   output logic                   out_valid,
   output esc_pkg::result_type    out_result
);

   typedef struct packed {
      logic [7:0]             year_since_1900;
      logic [8:0]             day_of_year;
      logic [8:0]             month_day;
      esc_pkg::clock_bus_type clock_fields;
   } carry_type;

   logic [3:0]          valid_ff;
   logic [8:0]          adj_day;
   logic [15:0]         num_in;
   carry_type           carry_in;
   carry_type           carry1_ff;
   carry_type           carry2_ff;
   carry_type           carry3_ff;
   logic [15:0]         num1_ff;
   logic [32:0]         month_prod;
   logic [3:0]          month2_ff;
   logic [3:0]          month3_ff;
   logic [15:0]         before3_ff;
   logic [15:0]         before_in;
   logic [9:0]          before_days;
   esc_pkg::result_type result_in;
   esc_pkg::result_type result_ff;

   // days past february shift by two, leap years take one or two back
   always_comb begin
      adj_day = in_year.day_number;
      if (in_year.day_number > esc_pkg::FebEndDay) begin
         adj_day = in_year.day_number + esc_pkg::FebSkip;
         if (in_year.leap) begin
            adj_day = (adj_day > esc_pkg::LeapMarchLimit) ? adj_day - 9'd1 : adj_day - 9'd2;
         end
      end
      num_in                   = 16'(adj_day) * esc_pkg::MonthScale + esc_pkg::MonthBase;
      carry_in.year_since_1900 = in_year.year_since_1900;
      carry_in.day_of_year     = in_year.day_number - 9'd1;
      carry_in.month_day       = adj_day;
      carry_in.clock_fields    = in_clock;
   end

   assign month_prod  = 33'(num1_ff) * 33'(esc_pkg::MonthRecip);
   assign before_in   = 16'(month2_ff) * esc_pkg::MonthStep - esc_pkg::MonthBase;
   assign before_days = esc_pkg::div100(before3_ff);

   always_comb begin
      result_in.year_since_1900 = carry3_ff.year_since_1900;
      result_in.month_index     = month3_ff - 4'd1;
      result_in.day_of_month    = 5'(carry3_ff.month_day - 9'(before_days));
      result_in.day_of_year     = carry3_ff.day_of_year;
      result_in.clock_fields    = carry3_ff.clock_fields;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         carry1_ff  <= carry_in;
         num1_ff    <= num_in;
         carry2_ff  <= carry1_ff;
         month2_ff  <= month_prod[esc_pkg::MonthRecipShift +: 4];
         carry3_ff  <= carry2_ff;
         month3_ff  <= month2_ff;
         before3_ff <= before_in;
         result_ff  <= result_in;
      end
   end

   assign out_valid  = valid_ff[3];
   assign out_result = result_ff;

endmodule

[design/epoch_seconds_to_calendar_unit.sv]
// epoch_seconds_to_calendar_unit: top level converting epoch seconds to calendar and clock fields
// depends on esc_pkg, esc_if, esc_day_split, esc_year_find, esc_clock_fields, esc_month_day
//
// usage
//   req_bus carries one 32-bit unsigned count of seconds since 1970-01-01 00:00:00 per
//   transaction; rsp_bus returns one transaction per request with year minus 1900, zero-based
//   month, day of month, zero-based day of year, weekday (0 is monday) and hour, minute, second
//   from request accept to response valid a transaction passes 2 stages of day split,
//   4 stages of year estimate and correction (time of day runs alongside), 4 stages of
//   month formula ending in the response register
//   throughput is one transaction per cycle while the response is not stalled; the pipeline
//   depth sets the latency and the reciprocal multipliers between stages set the stage depth
//   a stalled response holds the whole pipeline in place: req_bus.ready drops in the same
//   cycle, so nothing is lost or repeated, and flow resumes once the response is taken
//   reset is synchronous and clears only the valid bits; the block keeps no other state
//   and needs no configuration

module epoch_seconds_to_calendar_unit (
   input logic      clock,
   input logic      reset,
   esc_req_if.sink  req_bus,
   esc_rsp_if.source rsp_bus
);

   logic                   advance;
   logic                   day_valid;
   esc_pkg::day_bus_type   day_bus;
   logic                   year_valid;
   esc_pkg::year_bus_type  year_bus;
   esc_pkg::clock_bus_type clock_bus;
   logic                   result_valid;
   esc_pkg::result_type    result;

   // pipeline moves whenever the response slot is empty or being taken
   assign advance       = !result_valid || rsp_bus.ready;
   assign req_bus.ready = advance;

   // whole days, seconds of day and serial day number
   esc_day_split u_day_split (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_bus.valid),
      .in_seconds (req_bus.epoch_seconds),
      .out_valid  (day_valid),
      .out_bus    (day_bus)
   );

   // year estimate, correction and day of year
   esc_year_find u_year_find (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (day_valid),
      .in_bus    (day_bus),
      .out_valid (year_valid),
      .out_bus   (year_bus)
   );

   // hour, minute, second and weekday with matching latency
   esc_clock_fields u_clock_fields (
      .clock   (clock),
      .advance (advance),
      .in_bus  (day_bus),
      .out_bus (clock_bus)
   );

   // february correction, month and day of month; holds the response register
   esc_month_day u_month_day (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (year_valid),
      .in_year    (year_bus),
      .in_clock   (clock_bus),
      .out_valid  (result_valid),
      .out_result (result)
   );

   assign rsp_bus.valid            = result_valid;
   assign rsp_bus.year_since_1900  = result.year_since_1900;
   assign rsp_bus.month_index      = result.month_index;
   assign rsp_bus.day_of_month     = result.day_of_month;
   assign rsp_bus.day_of_year      = result.day_of_year;
   assign rsp_bus.weekday          = result.clock_fields.weekday;
   assign rsp_bus.hour_of_day      = result.clock_fields.hour_of_day;
   assign rsp_bus.minute_of_hour   = result.clock_fields.minute_of_hour;
   assign rsp_bus.second_of_minute = result.clock_fields.second_of_minute;

`ifndef NO_ASSERTIONS
   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("response valid right after reset");

   // reciprocal divisions land in range for the time of day
   a_clock_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.hour_of_day <= 5'd23) && (rsp_bus.minute_of_hour <= 6'd59)
         && (rsp_bus.second_of_minute <= 6'd59) && (rsp_bus.weekday <= 3'd6))
      else $error("time of day or weekday out of range");

   // year correction and month formula land in range
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.month_index <= 4'd11) && (rsp_bus.day_of_month != 5'd0)
         && (rsp_bus.day_of_year <= 9'd365) && (rsp_bus.year_since_1900 >= 8'd70)
         && (rsp_bus.year_since_1900 <= 8'd206))
      else $error("calendar date out of range");
`endif

endmodule
